FILE: hdl/pbr_pkg.sv
// Shared types and constants for the RGBA palette builder.
// Used by pbr_cell and palette_builder_rgba_unit; no dependencies.
package pbr_pkg;

  localparam int COUNT_W = 7;   // holds 0..64 entries
  localparam int INDEX_W = 6;   // addresses up to 64 entries
  localparam int WORD_W  = 32;  // packed R,G,B,A

  localparam logic [7:0] TRANSPARENT_CODE = 8'd255;
  localparam logic [7:0] OPAQUE_ALPHA     = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
    logic       first_of_image;
  } pixel_t;

  typedef struct packed {
    logic [7:0]         color_offset;
    logic               added_entry;
    logic               palette_full;
    logic [COUNT_W-1:0] entries_used;
  } result_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  word;
    logic               found;
    logic [INDEX_W-1:0] hit_index;
  } probe_t;

  // Broadcast write into one cell
  typedef struct packed {
    logic               enable;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
  } entry_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

FILE: hdl/pbr_cell.sv
// One palette cell: holds one stored color and compares the passing search token.
// Depends on pbr_pkg.
module pbr_cell
  import pbr_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  probe_t             probe_in,
  output probe_t             probe_out,
  input  logic [COUNT_W-1:0] count,
  input  entry_wr_t          wr
);

  localparam logic [COUNT_W-1:0] MY_COUNT = COUNT_W'(CELL_INDEX);
  localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(CELL_INDEX);

  logic [WORD_W-1:0] entry;
  logic              match;

  // only cells below the fill count hold live colors
  assign match = (MY_COUNT < count) && (entry == probe_in.word);

  always_ff @(posedge clk) begin
    if (wr.enable && (wr.index == MY_INDEX)) begin
      entry <= wr.word;
    end
  end

  // keep the earliest hit
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.word      <= probe_in.word;
    probe_out.found     <= probe_in.found | match;
    probe_out.hit_index <= probe_in.found ? probe_in.hit_index : MY_INDEX;
  end

endmodule

FILE: hdl/palette_builder_rgba_unit.sv
// RGBA palette builder: a row of PALETTE_DEPTH cells searched by a passing token.
// An opaque item's result is registered once the token has passed the last cell; the
// token moves one cell per cycle. A transparent item's result skips the search.
// One item is in work at a time: the next is accepted only once the last result is
// registered, and later still while a finished result waits.
// Synchronous reset empties the palette (fill count to zero) and clears use_alpha.
module palette_builder_rgba_unit
  import pbr_pkg::*;
#(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pixel_valid,
  output logic    pixel_ready,
  input  pixel_t  pixel,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(PALETTE_DEPTH);

  state_t             state, state_next;
  logic               use_alpha;
  logic [COUNT_W-1:0] count;
  logic [WORD_W-1:0]  pix_word;
  logic               launch;
  logic               transp;
  logic               hit_found;
  logic [INDEX_W-1:0] hit_index;

  logic               accept;
  logic [7:0]         alpha_eff;
  logic               pixel_transp;
  logic               slot_free;
  logic               finish_go;
  result_t            result_next;
  entry_wr_t          wr;

  probe_t probes [0:PALETTE_DEPTH];

  assign cfg_ready    = 1'b1;
  assign pixel_ready  = (state == ST_IDLE);
  assign accept       = pixel_valid && pixel_ready;
  assign alpha_eff    = use_alpha ? pixel.opacity : OPAQUE_ALPHA;
  assign pixel_transp = (alpha_eff == 8'd0);
  assign slot_free    = !result_valid || result_ready;
  assign finish_go    = (state == ST_FINISH) && slot_free;

  assign probes[0] = '{valid: launch, word: pix_word, found: 1'b0, hit_index: '0};

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    pbr_cell #(.CELL_INDEX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (probes[i]),
      .probe_out (probes[i+1]),
      .count     (count),
      .wr        (wr)
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = pixel_transp ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (probes[PALETTE_DEPTH].valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result and palette write
  always_comb begin
    result_next.color_offset = TRANSPARENT_CODE;
    result_next.added_entry  = 1'b0;
    result_next.palette_full = 1'b0;
    result_next.entries_used = count;
    wr.enable = 1'b0;
    wr.index  = count[INDEX_W-1:0];
    wr.word   = pix_word;
    if (!transp) begin
      if (hit_found) begin
        result_next.color_offset = {hit_index, 2'b00};
      end else if (count < DEPTH_COUNT) begin
        result_next.color_offset = {count[INDEX_W-1:0], 2'b00};
        result_next.added_entry  = 1'b1;
        result_next.entries_used = count + COUNT_W'(1);
        wr.enable                = finish_go;
      end else begin
        result_next.palette_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      use_alpha    <= 1'b0;
      count        <= '0;
      launch       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && !pixel_transp;
      if (cfg_valid && cfg_ready) begin
        use_alpha <= cfg_data;
      end
      // clear the palette ahead of the item that asks for it
      if (accept && pixel.first_of_image) begin
        count <= '0;
      end else if (wr.enable) begin
        count <= result_next.entries_used;
      end
      if (finish_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_word  <= {pixel.red, pixel.green, pixel.blue, alpha_eff};
      transp    <= pixel_transp;
      hit_found <= 1'b0;
    end else if ((state == ST_SEARCH) && probes[PALETTE_DEPTH].valid) begin
      hit_found <= probes[PALETTE_DEPTH].found;
      hit_index <= probes[PALETTE_DEPTH].hit_index;
    end
    if (finish_go) begin
      result <= result_next;
    end
  end

endmodule

FILE: sim/palette_builder_rgba_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for palette_builder_rgba_unit: directed table, palette fill and random images,
// each result checked against a typed expectation or a local palette predictor. Depends on pbr_pkg and the unit.
module palette_builder_rgba_unit_tb;
  import pbr_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = DEPTH + 8;

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       cfg_value;
    logic [7:0] red, green, blue, opacity;
    logic       first;
    logic       typed;
    result_t    want;
  } row_t;

  localparam result_t NO_RESULT = '0;

  localparam row_t DIRECTED_ROWS [17] = '{
    // use_alpha at reset: alpha forced opaque
    '{ROW_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd1}},
    '{ROW_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'h04, 1'b1, 1'b0, 7'd2}},
    '{ROW_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd2}},
    '{ROW_PIXEL, 1'b0, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0, 1'b1, '{8'h08, 1'b1, 1'b0, 7'd3}},
    '{ROW_CFG,   1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0},
    // alpha taken from the item: zero alpha is transparent
    '{ROW_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd3}},
    '{ROW_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd3}},
    '{ROW_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd3}},
    '{ROW_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'h04, 1'b0, 1'b0, 7'd3}},
    '{ROW_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b0, 1'b1, '{8'h0C, 1'b1, 1'b0, 7'd4}},
    '{ROW_PIXEL, 1'b0, 8'h12, 8'h34, 8'h56, 8'hFF, 1'b0, 1'b1, '{8'h08, 1'b0, 1'b0, 7'd4}},
    // clear with a transparent item, then clear with an opaque one
    '{ROW_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0}},
    '{ROW_PIXEL, 1'b0, 8'hAA, 8'h55, 8'hAA, 8'h01, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd1}},
    '{ROW_PIXEL, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hFE, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hFE, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd1}},
    '{ROW_CFG,   1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, 1'b0, 8'h55, 8'hAA, 8'h55, 8'h00, 1'b0, 1'b0, '0}
  };

  logic    clk = 1'b0;
  logic    rst;
  logic    pixel_valid;
  logic    pixel_ready;
  pixel_t  pixel;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic    cfg_data;

  // predictor state
  logic [31:0]        palette_copy [DEPTH];
  logic [COUNT_W-1:0] fill_count;
  logic               alpha_enabled;

  result_t answers_due [$];
  int      error_count = 0;
  int      burst_left = 0;

  palette_builder_rgba_unit #(.PALETTE_DEPTH(DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Match one color against the palette copy and update it.
  function automatic result_t lookup_color(input pixel_t px);
    result_t     res;
    logic [7:0]  alpha;
    logic [31:0] word;
    logic        found;
    alpha = alpha_enabled ? px.opacity : OPAQUE_ALPHA;
    res = '0;
    res.color_offset = TRANSPARENT_CODE;
    if (px.first_of_image) fill_count = '0;
    if (alpha != 8'd0) begin
      word = {px.red, px.green, px.blue, alpha};
      found = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
        if (!found && j < fill_count && palette_copy[j] == word) begin
          res.color_offset = 8'(j * 4);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (fill_count < DEPTH) begin
          palette_copy[fill_count] = word;
          res.color_offset = 8'(fill_count * 4);
          fill_count = fill_count + COUNT_W'(1);
          res.added_entry = 1'b1;
        end else begin
          res.palette_full = 1'b1;
        end
      end
    end
    res.entries_used = fill_count;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %p", $time, result);
        error_count++;
      end else begin
        check_field("color_offset", answers_due[0].color_offset, result.color_offset);
        check_field("added_entry", answers_due[0].added_entry, result.added_entry);
        check_field("palette_full", answers_due[0].palette_full, result.palette_full);
        check_field("entries_used", answers_due[0].entries_used, result.entries_used);
        void'(answers_due.pop_front());
      end
    end
  end

  // Receiver: stall on a rotating 16-bit pattern, drawn anew now and then from four kinds.
  initial begin
    logic [15:0] stall_pattern;
    int          phase;
    result_ready = 1'b0;
    stall_pattern = 16'hFFFF;
    phase = 0;
    forever begin
      @(negedge clk);
      if (phase % 200 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'h0001 << $urandom_range(0, 15);
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
      end
      result_ready <= stall_pattern[phase % 16];
      phase++;
    end
  end

  // Send one item; a typed expectation replaces the predicted one.
  task automatic send_pixel(input pixel_t px, input logic typed, input result_t want);
    result_t predicted;
    result_t expected;
    int      gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) pixel_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pixel <= px;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (!pixel_ready);
    predicted = lookup_color(px);
    expected = typed ? want : predicted;
    answers_due = {answers_due, expected};
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk) pixel_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_use_alpha(input logic value);
    wait_idle();
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    alpha_enabled = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    pixel_t      px;
    row_t        row;
    logic [31:0] pool [80];
    int          pool_size;
    int          image_len;
    int          idx;
    int          items_sent;
    logic        wide_image;

    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    fill_count = '0;
    alpha_enabled = 1'b0;
    for (int j = 0; j < DEPTH; j++) palette_copy[j] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_use_alpha(row.cfg_value);
      end else begin
        px = '{row.red, row.green, row.blue, row.opacity, row.first};
        send_pixel(px, row.typed, row.want);
      end
    end

    // Fill the palette to the last entry, then miss, hit the last entry, and clear.
    for (int i = 0; i < DEPTH; i++) begin
      px = '{8'(i), 8'hA5 ^ 8'(i), 8'h0F, 8'($urandom), i == 0};
      send_pixel(px, 1'b0, NO_RESULT);
    end
    send_pixel('{8'hC8, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{8'hFF, 1'b0, 1'b1, 7'd64});
    send_pixel('{8'h3F, 8'h9A, 8'h0F, 8'h00, 1'b0}, 1'b1, '{8'hFC, 1'b0, 1'b0, 7'd64});
    write_use_alpha(1'b1);
    send_pixel('{8'hC8, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd64});
    send_pixel('{8'h3F, 8'h9A, 8'h0F, 8'hFF, 1'b0}, 1'b1, '{8'hFC, 1'b0, 1'b0, 7'd64});
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, '{8'hFF, 1'b0, 1'b0, 7'd0});

    // Random images: most open with a clear, and each draws from a color pool.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_use_alpha(1'($urandom));
      wide_image = ($urandom_range(0, 7) == 0);
      if (wide_image) begin
        pool_size = $urandom_range(66, 80);
        image_len = $urandom_range(66, 75);
      end else begin
        pool_size = $urandom_range(1, 12);
        image_len = $urandom_range(3, 20);
      end
      for (int j = 0; j < pool_size; j++) pool[j] = $urandom;
      for (int i = 0; i < image_len; i++) begin
        if (wide_image && $urandom_range(0, 9) != 0) idx = i % pool_size;
        else idx = $urandom_range(0, pool_size - 1);
        px = '{pool[idx][31:24], pool[idx][23:16], pool[idx][15:8], pool[idx][7:0], 1'b0};
        if ($urandom_range(0, 7) == 0) px.opacity = 8'h00;
        if ($urandom_range(0, 9) == 0) px = pixel_t'($urandom);
        // mostly clear at the first item, rarely elsewhere
        if (i == 0) px.first_of_image = ($urandom_range(0, 9) != 0);
        else px.first_of_image = ($urandom_range(0, 49) == 0);
        send_pixel(px, 1'b0, NO_RESULT);
        items_sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && answers_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
